// ===== sv/pdms_pkg.sv =====
// ----------------------------------------------------------------------------
// pdms_pkg
// Types and fixed constants shared by the PLL setting search block.
// ----------------------------------------------------------------------------
package pdms_pkg;

    localparam int unsigned FREQ_W    = 32;
    localparam int unsigned DIV_W     = 8;
    localparam int unsigned MUL_W     = 12;
    localparam int unsigned WORD_W    = 27;
    localparam int unsigned DIVIDED_W = 25;   // the window tops out at 32 MHz
    localparam int unsigned ERR_W     = 31;   // holds the start value 2^30

    localparam logic [FREQ_W-1:0] RANGE_SPLIT_HZ = 32'd155000000;
    localparam logic [FREQ_W-1:0] TARGET_MAX_HZ  = 32'd240000000;
    localparam logic [FREQ_W-1:0] INPUT_MIN_HZ   = 32'd100000;
    localparam logic [FREQ_W-1:0] INPUT_MAX_HZ   = 32'd32000000;
    localparam logic [FREQ_W-1:0] MULT_MAX       = 32'd2048;
    localparam logic [FREQ_W-1:0] MULT_MIN       = 32'd2;
    localparam logic [15:0]       RANGE_HIGH_BITS = 16'hbe00;
    localparam logic [15:0]       RANGE_LOW_BITS  = 16'h3e00;
    localparam logic [ERR_W-1:0]  ERROR_START    = 31'h4000_0000;

    typedef struct packed {
        logic [FREQ_W-1:0] ref_freq_hz;
        logic [FREQ_W-1:0] target_freq_hz;
    } t_in_beat;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] setting_word;
        logic [DIV_W-1:0]  best_divider;
        logic [MUL_W-1:0]  best_multiplier;
    } t_out_beat;

endpackage

// ===== sv/pdms_if.sv =====
// ----------------------------------------------------------------------------
// pdms_in_if / pdms_out_if
// Valid/ready channels that carry the request and the result beats.
// ----------------------------------------------------------------------------
interface pdms_in_if
    import pdms_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pdms_out_if
    import pdms_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/pll_divider_multiplier_search.sv =====
// ----------------------------------------------------------------------------
// pll_divider_multiplier_search
// Searches input dividers for the PLL setting closest to a target frequency.
// ----------------------------------------------------------------------------
// One request beat runs a search over dividers 1 to DIVIDER_LIMIT on a single
// shared 32-bit restoring divider that resolves one quotient bit per cycle.
// Each divider costs one division of the reference and, when the divided
// input falls in the 100 kHz to 32 MHz window, a second division of the
// target, plus a check state after each. The divider limit defaults to 255;
// an exact match or a too-small multiplier ends the search early, and a
// target above 240 MHz skips it. The request side is not ready while a
// search runs. The result sits in an output register, so a new request is
// taken while the previous result waits to be read.
// ----------------------------------------------------------------------------
module pll_divider_multiplier_search
    import pdms_pkg::*;
#(
    parameter int unsigned DIVIDER_LIMIT = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pdms_in_if.sink       i_in,
    pdms_out_if.source    o_out
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV1   = 3'd1;
    localparam logic [2:0] ST_CHK1   = 3'd2;
    localparam logic [2:0] ST_DIV2   = 3'd3;
    localparam logic [2:0] ST_CHK2   = 3'd4;
    localparam logic [2:0] ST_NEXT   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DIVIDER_LIMIT);

    logic [2:0]           r_state, n_state;
    logic [FREQ_W-1:0]    r_ref, n_ref;
    logic [FREQ_W-1:0]    r_tgt, n_tgt;
    logic [DIV_W-1:0]     r_div, n_div;
    logic [FREQ_W-1:0]    r_rem, n_rem;
    logic [FREQ_W-1:0]    r_quo, n_quo;
    logic [FREQ_W-1:0]    r_dvs, n_dvs;
    logic [4:0]           r_cnt, n_cnt;
    logic [ERR_W-1:0]     r_best_err, n_best_err;
    logic [DIV_W-1:0]     r_best_div, n_best_div;
    logic [MUL_W-1:0]     r_best_mul, n_best_mul;
    logic                 r_fail, n_fail;
    logic                 r_exact, n_exact;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    // Shared divider step: shift in the next dividend bit, try to subtract.
    logic [FREQ_W:0]      w_shift;
    logic [FREQ_W:0]      w_diff;
    logic                 w_ge;
    logic                 w_out_free;
    logic                 w_success;
    logic [15:0]          w_range;

    assign w_shift    = {r_rem, r_quo[FREQ_W-1]};
    assign w_diff     = w_shift - {1'b0, r_dvs};
    assign w_ge       = ~w_diff[FREQ_W];
    assign w_out_free = ~r_out_valid | o_out.ready;
    assign w_success  = ~r_fail
                      & (r_exact | ({1'b0, r_best_err} <= {5'b0, r_tgt[FREQ_W-1:5]}));
    assign w_range    = (r_tgt > RANGE_SPLIT_HZ) ? RANGE_HIGH_BITS : RANGE_LOW_BITS;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_ref       = r_ref;
        n_tgt       = r_tgt;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_best_err  = r_best_err;
        n_best_div  = r_best_div;
        n_best_mul  = r_best_mul;
        n_fail      = r_fail;
        n_exact     = r_exact;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_ref      = i_in.data.ref_freq_hz;
                    n_tgt      = i_in.data.target_freq_hz;
                    n_best_err = ERROR_START;
                    n_best_div = '0;
                    n_best_mul = '0;
                    n_exact    = 1'b0;
                    n_div      = DIV_W'(1);
                    n_quo      = i_in.data.ref_freq_hz;
                    n_rem      = '0;
                    n_dvs      = FREQ_W'(1);
                    n_cnt      = '0;
                    if (i_in.data.target_freq_hz > TARGET_MAX_HZ) begin
                        n_fail  = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        n_fail  = 1'b0;
                        n_state = ST_DIV1;
                    end
                end
            end
            ST_DIV1, ST_DIV2: begin
                n_rem = w_ge ? w_diff[FREQ_W-1:0] : w_shift[FREQ_W-1:0];
                n_quo = {r_quo[FREQ_W-2:0], w_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = (r_state == ST_DIV1) ? ST_CHK1 : ST_CHK2;
                end
            end
            ST_CHK1: begin
                // r_quo holds the divided reference.
                if (r_quo < INPUT_MIN_HZ || r_quo > INPUT_MAX_HZ) begin
                    n_state = ST_NEXT;
                end else begin
                    n_dvs   = {{(FREQ_W-DIVIDED_W){1'b0}}, r_quo[DIVIDED_W-1:0]};
                    n_quo   = r_tgt;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV2;
                end
            end
            ST_CHK2: begin
                // r_quo is the multiplier, r_rem the error left over.
                if (r_quo > MULT_MAX) begin
                    n_state = ST_NEXT;
                end else if (r_quo < MULT_MIN) begin
                    n_fail  = 1'b1;
                    n_state = ST_FINISH;
                end else if (r_rem < {1'b0, r_best_err}) begin
                    n_best_err = r_rem[ERR_W-1:0];
                    n_best_div = r_div;
                    n_best_mul = r_quo[MUL_W-1:0];
                    if (r_rem == '0) begin
                        n_exact = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_div == DIV_LAST) begin
                    n_state = ST_FINISH;
                end else begin
                    n_div   = r_div + DIV_W'(1);
                    n_quo   = r_ref;
                    n_rem   = '0;
                    n_dvs   = {{(FREQ_W-DIV_W){1'b0}}, r_div + DIV_W'(1)};
                    n_cnt   = '0;
                    n_state = ST_DIV1;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_success) begin
                        n_out.found           = 1'b1;
                        n_out.setting_word    = {r_best_mul[MUL_W-2:0] - 11'd1,
                                                 w_range[15:8], r_best_div};
                        n_out.best_divider    = r_best_div;
                        n_out.best_multiplier = r_best_mul;
                    end else begin
                        n_out = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ref      <= n_ref;
        r_tgt      <= n_tgt;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dvs      <= n_dvs;
        r_best_err <= n_best_err;
        r_best_div <= n_best_div;
        r_best_mul <= n_best_mul;
        r_fail     <= n_fail;
        r_exact    <= n_exact;
        r_out      <= n_out;
    end

endmodule

// ===== sv/pdms_checker.sv =====
// ----------------------------------------------------------------------------
// pdms_checker
// Port-level checks for the PLL setting search block, bound to the top level.
// ----------------------------------------------------------------------------
module pdms_checker
    import pdms_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_beat i_out_data
);

    // A result beat that is not taken holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    // Once a request beat is taken, the search keeps the request side closed.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while a search was starting");

    // A failed search reports all zeros.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.found |->
            i_out_data.setting_word == '0 && i_out_data.best_divider == '0
            && i_out_data.best_multiplier == '0)
        else $error("failed search with nonzero result fields");

    // A found setting packs its divider, multiplier and range bits consistently.
    a_word_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.found |->
            i_out_data.best_divider != '0
            && i_out_data.best_multiplier >= 12'd2
            && i_out_data.best_multiplier <= 12'd2048
            && i_out_data.setting_word[7:0] == i_out_data.best_divider
            && i_out_data.setting_word[26:16] == 11'(i_out_data.best_multiplier - 12'd1)
            && (i_out_data.setting_word[15:8] == RANGE_HIGH_BITS[15:8]
                || i_out_data.setting_word[15:8] == RANGE_LOW_BITS[15:8]))
        else $error("setting word does not match divider and multiplier");

endmodule

bind pll_divider_multiplier_search pdms_checker u_pdms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
